[design/lccs_pkg.sv]
// -----------------------------------------------------------------------------
// lccs_pkg: shared types and constants
// Register indexes and reset values for the layer clip, crop and scale block.
// -----------------------------------------------------------------------------
package lccs_pkg;

   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LAYER_SRC_X = 3'd0,
      CSR_LAYER_SRC_Y = 3'd1,
      CSR_LAYER_SRC_W = 3'd2,
      CSR_LAYER_SRC_H = 3'd3,
      CSR_LAYER_DST_X = 3'd4,
      CSR_LAYER_DST_Y = 3'd5,
      CSR_LAYER_DST_W = 3'd6,
      CSR_LAYER_DST_H = 3'd7
   } csr_index_type;

   localparam int LAYER_W_RESET = 1920;
   localparam int LAYER_H_RESET = 1080;

endpackage

[design/lccs_if.sv]
// -----------------------------------------------------------------------------
// lccs_req_if / lccs_rsp_if: valid/ready channels
// Surface request beats in, clipped and scaled rectangle beats out.
// -----------------------------------------------------------------------------
interface lccs_req_if #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 4
) ();
   logic                            valid;
   logic                            ready;
   logic [COORD_BITS+FRAC_BITS-1:0] surf_src_x;
   logic [COORD_BITS+FRAC_BITS-1:0] surf_src_y;
   logic [COORD_BITS+FRAC_BITS-1:0] surf_src_w;
   logic [COORD_BITS+FRAC_BITS-1:0] surf_src_h;
   logic signed [COORD_BITS:0]      dst_x;
   logic signed [COORD_BITS:0]      dst_y;
   logic [COORD_BITS-1:0]           dst_w;
   logic [COORD_BITS-1:0]           dst_h;

   modport source (output valid, surf_src_x, surf_src_y, surf_src_w, surf_src_h,
                   dst_x, dst_y, dst_w, dst_h, input ready);
   modport sink   (input valid, surf_src_x, surf_src_y, surf_src_w, surf_src_h,
                   dst_x, dst_y, dst_w, dst_h, output ready);
endinterface

interface lccs_rsp_if #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 4
) ();
   logic                            valid;
   logic                            ready;
   logic                            fully_cropped;
   logic [COORD_BITS+FRAC_BITS-1:0] out_src_x;
   logic [COORD_BITS+FRAC_BITS-1:0] out_src_y;
   logic [COORD_BITS+FRAC_BITS-1:0] out_src_w;
   logic [COORD_BITS+FRAC_BITS-1:0] out_src_h;
   logic [COORD_BITS+FRAC_BITS-1:0] out_dst_x;
   logic [COORD_BITS+FRAC_BITS-1:0] out_dst_y;
   logic [COORD_BITS+FRAC_BITS-1:0] out_dst_w;
   logic [COORD_BITS+FRAC_BITS-1:0] out_dst_h;

   modport source (output valid, fully_cropped, out_src_x, out_src_y, out_src_w,
                   out_src_h, out_dst_x, out_dst_y, out_dst_w, out_dst_h, input ready);
   modport sink   (input valid, fully_cropped, out_src_x, out_src_y, out_src_w,
                   out_src_h, out_dst_x, out_dst_y, out_dst_w, out_dst_h, output ready);
endinterface

[design/lccs_div.sv]
// -----------------------------------------------------------------------------
// lccs_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage, NUM_BITS stages deep.
// -----------------------------------------------------------------------------
module lccs_div #(
   parameter int NUM_BITS = 30,
   parameter int DEN_BITS = 13
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [NUM_BITS-1:0] quo
);
   logic [NUM_BITS-1:0] num_ff [NUM_BITS];
   logic [DEN_BITS-1:0] rem_ff [NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [NUM_BITS];

   for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
      logic [NUM_BITS-1:0] num_src;
      logic [DEN_BITS-1:0] rem_src;
      logic [DEN_BITS-1:0] den_src;
      logic [DEN_BITS:0]   trial;
      logic                take;
      logic [NUM_BITS-1:0] num_in;
      logic [DEN_BITS-1:0] rem_in;

      if (i == 0) begin : g_first
         assign num_src = num;
         assign rem_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign num_src = num_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
      end

      // shift in the next numerator bit, subtract when it fits
      assign trial = {rem_src, num_src[NUM_BITS-1]};
      assign take  = trial >= {1'b0, den_src};
      assign rem_in = take ? DEN_BITS'(trial - {1'b0, den_src}) : trial[DEN_BITS-1:0];
      if (NUM_BITS > 1) begin : g_wide
         assign num_in = {num_src[NUM_BITS-2:0], take};
      end else begin : g_narrow
         assign num_in = take;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            num_ff[i] <= num_in;
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_src;
         end
      end
   end

   assign quo = num_ff[NUM_BITS-1];
endmodule

[design/lccs_axis.sv]
// -----------------------------------------------------------------------------
// lccs_axis: one axis of clip, source trim and layer scale
// Clip compare, multiply, divide (NUM_BITS stages) and saturate, all pipelined.
// -----------------------------------------------------------------------------
module lccs_axis #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 4
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [COORD_BITS-1:0]           win_pos,
   input  logic [COORD_BITS-1:0]           win_size,
   input  logic [COORD_BITS-1:0]           lay_pos,
   input  logic [COORD_BITS-1:0]           lay_size,
   input  logic [COORD_BITS+FRAC_BITS-1:0] src_pos,
   input  logic [COORD_BITS+FRAC_BITS-1:0] src_size,
   input  logic signed [COORD_BITS:0]      pos,
   input  logic [COORD_BITS-1:0]           size,
   output logic                            cropped,
   output logic [COORD_BITS+FRAC_BITS-1:0] out_src_pos,
   output logic [COORD_BITS+FRAC_BITS-1:0] out_src_size,
   output logic [COORD_BITS+FRAC_BITS-1:0] out_dst_pos,
   output logic [COORD_BITS+FRAC_BITS-1:0] out_dst_size
);
   localparam int CB = COORD_BITS;
   localparam int FX = COORD_BITS + FRAC_BITS;
   localparam int NW = 2 * COORD_BITS + FRAC_BITS;
   localparam int SW = COORD_BITS + 3;
   localparam logic [NW:0] FIX_MAX = {{(NW+1-FX){1'b0}}, {FX{1'b1}}};

   // clip stage
   logic signed [SW-1:0] p_s, sz_s, wp_s, ws_s, c1_s, c2_s, pos1_s, size1_s, size2_s;
   logic                 crop_in;
   logic [CB-1:0]        c1_in, c2_in;

   always_comb begin
      p_s     = SW'(pos);
      sz_s    = SW'(signed'({1'b0, size}));
      wp_s    = SW'(signed'({1'b0, win_pos}));
      ws_s    = SW'(signed'({1'b0, win_size}));
      crop_in = (size == '0) || (src_size == '0) || (win_size == '0) ||
                (p_s >= wp_s + ws_s) || (p_s + sz_s <= wp_s);
      c1_s = wp_s - p_s;
      if (c1_s > 0) begin
         pos1_s  = '0;
         size1_s = sz_s - c1_s;
         c1_in   = c1_s[CB-1:0];
      end else begin
         pos1_s  = p_s - wp_s;
         size1_s = sz_s;
         c1_in   = '0;
      end
      c2_s = pos1_s + size1_s - ws_s;
      if (c2_s > 0) begin
         size2_s = size1_s - c2_s;
         c2_in   = c2_s[CB-1:0];
      end else begin
         size2_s = size1_s;
         c2_in   = '0;
      end
   end

   logic          crop_a_ff;
   logic [CB-1:0] c1_a_ff, c2_a_ff, pos1_a_ff, size2_a_ff, d0_a_ff;
   logic [FX-1:0] spos_a_ff, s0_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         crop_a_ff  <= crop_in;
         c1_a_ff    <= c1_in;
         c2_a_ff    <= c2_in;
         pos1_a_ff  <= pos1_s[CB-1:0];
         size2_a_ff <= size2_s[CB-1:0];
         d0_a_ff    <= size;
         spos_a_ff  <= src_pos;
         s0_a_ff    <= src_size;
      end
   end

   // multiply stage
   logic          crop_b_ff;
   logic [NW-1:0] m1_b_ff, m2_b_ff, np_b_ff, ns_b_ff;
   logic [CB-1:0] d0_b_ff;
   logic [FX-1:0] spos_b_ff, s0_b_ff;
   logic [2*CB-1:0] np_prod, ns_prod;

   assign np_prod = pos1_a_ff * lay_size;
   assign ns_prod = size2_a_ff * lay_size;

   always_ff @(posedge clock) begin
      if (en) begin
         crop_b_ff <= crop_a_ff;
         m1_b_ff   <= NW'(c1_a_ff) * NW'(s0_a_ff);
         m2_b_ff   <= NW'(c2_a_ff) * NW'(s0_a_ff);
         np_b_ff   <= NW'({np_prod, {FRAC_BITS{1'b0}}});
         ns_b_ff   <= NW'({ns_prod, {FRAC_BITS{1'b0}}});
         d0_b_ff   <= d0_a_ff;
         spos_b_ff <= spos_a_ff;
         s0_b_ff   <= s0_a_ff;
      end
   end

   // divide stages
   logic [NW-1:0] q1, q2, q3, q4;

   lccs_div #(.NUM_BITS(NW), .DEN_BITS(CB)) u_div_t1 (
      .clock(clock), .en(en), .num(m1_b_ff), .den(d0_b_ff), .quo(q1));
   lccs_div #(.NUM_BITS(NW), .DEN_BITS(CB)) u_div_t2 (
      .clock(clock), .en(en), .num(m2_b_ff), .den(d0_b_ff), .quo(q2));
   lccs_div #(.NUM_BITS(NW), .DEN_BITS(CB)) u_div_pos (
      .clock(clock), .en(en), .num(np_b_ff), .den(win_size), .quo(q3));
   lccs_div #(.NUM_BITS(NW), .DEN_BITS(CB)) u_div_size (
      .clock(clock), .en(en), .num(ns_b_ff), .den(win_size), .quo(q4));

   logic          crop_d_ff [NW];
   logic [FX-1:0] spos_d_ff [NW];
   logic [FX-1:0] s0_d_ff   [NW];

   always_ff @(posedge clock) begin
      if (en) begin
         crop_d_ff[0] <= crop_b_ff;
         spos_d_ff[0] <= spos_b_ff;
         s0_d_ff[0]   <= s0_b_ff;
         for (int i = 1; i < NW; i++) begin
            crop_d_ff[i] <= crop_d_ff[i-1];
            spos_d_ff[i] <= spos_d_ff[i-1];
            s0_d_ff[i]   <= s0_d_ff[i-1];
         end
      end
   end

   // trim, offset and saturate
   logic [FX:0]   sp_sum;
   logic [FX-1:0] ss_in;
   logic [NW:0]   dp_sum, ds_ext;
   logic [FX-1:0] sp_in, dp_in, ds_in;

   always_comb begin
      sp_sum = {1'b0, spos_d_ff[NW-1]} + {1'b0, q1[FX-1:0]};
      sp_in  = sp_sum[FX] ? {FX{1'b1}} : sp_sum[FX-1:0];
      // both trims together never exceed the source size
      ss_in  = s0_d_ff[NW-1] - q1[FX-1:0] - q2[FX-1:0];
      dp_sum = {1'b0, q3} + (NW+1)'({lay_pos, {FRAC_BITS{1'b0}}});
      dp_in  = (dp_sum > FIX_MAX) ? {FX{1'b1}} : dp_sum[FX-1:0];
      ds_ext = {1'b0, q4};
      ds_in  = (ds_ext > FIX_MAX) ? {FX{1'b1}} : ds_ext[FX-1:0];
   end

   logic          crop_ff;
   logic [FX-1:0] sp_ff, ss_ff, dp_ff, ds_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         crop_ff <= crop_d_ff[NW-1];
         sp_ff   <= sp_in;
         ss_ff   <= ss_in;
         dp_ff   <= dp_in;
         ds_ff   <= ds_in;
      end
   end

   assign cropped      = crop_ff;
   assign out_src_pos  = sp_ff;
   assign out_src_size = ss_ff;
   assign out_dst_pos  = dp_ff;
   assign out_dst_size = ds_ff;
endmodule

[design/layer_clip_crop_and_scale.sv]
// -----------------------------------------------------------------------------
// layer_clip_crop_and_scale: surface clip to layer window and screen scale
// -----------------------------------------------------------------------------
// Each req beat carries one surface's source rectangle (fixed point) and
// destination rectangle (layer pixels). Each rsp beat returns the source
// rectangle trimmed to the layer source window and the destination scaled to
// screen space with FRAC_BITS fraction bits, or fully_cropped with zeros.
// The layer window is written through csr_we / csr_index / csr_wdata; the user
// must write it only while no beat is in flight: the block does not enforce it.
// Throughput: one beat per cycle while rsp does not stall. The pipeline holds
// a clip stage, a multiply stage, one stage per quotient bit of the pipelined
// dividers and a saturate stage.
// The whole pipeline advances together; when rsp stalls with a result held,
// req.ready drops and every stage holds. Bubbles in flight are not squeezed
// out; a stall freezes the whole pipeline. Reset clears valid bits and loads
// the layer registers with their defaults.
// -----------------------------------------------------------------------------
module layer_clip_crop_and_scale #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   lccs_req_if.sink                      req,
   lccs_rsp_if.source                    rsp,
   input  logic                          csr_we,
   input  lccs_pkg::csr_index_type       csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata
);
   import lccs_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int FX  = COORD_BITS + FRAC_BITS;
   localparam int LAT = 2 * COORD_BITS + FRAC_BITS + 3;

   logic [CB-1:0] lsx_ff, lsy_ff, lsw_ff, lsh_ff, ldx_ff, ldy_ff, ldw_ff, ldh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lsx_ff <= '0;
         lsy_ff <= '0;
         lsw_ff <= CB'(LAYER_W_RESET);
         lsh_ff <= CB'(LAYER_H_RESET);
         ldx_ff <= '0;
         ldy_ff <= '0;
         ldw_ff <= CB'(LAYER_W_RESET);
         ldh_ff <= CB'(LAYER_H_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAYER_SRC_X: lsx_ff <= csr_wdata;
            CSR_LAYER_SRC_Y: lsy_ff <= csr_wdata;
            CSR_LAYER_SRC_W: lsw_ff <= csr_wdata;
            CSR_LAYER_SRC_H: lsh_ff <= csr_wdata;
            CSR_LAYER_DST_X: ldx_ff <= csr_wdata;
            CSR_LAYER_DST_Y: ldy_ff <= csr_wdata;
            CSR_LAYER_DST_W: ldw_ff <= csr_wdata;
            CSR_LAYER_DST_H: ldh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic en;
   logic valid_ff [LAT];

   // advance unless a finished beat is held by the receiver
   assign en        = !valid_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req.valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   logic          crop_x, crop_y;
   logic [FX-1:0] sx, sw, dx, dw, sy, sh, dy, dh;

   lccs_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_x (
      .clock(clock), .en(en),
      .win_pos(lsx_ff), .win_size(lsw_ff), .lay_pos(ldx_ff), .lay_size(ldw_ff),
      .src_pos(req.surf_src_x), .src_size(req.surf_src_w),
      .pos(req.dst_x), .size(req.dst_w),
      .cropped(crop_x), .out_src_pos(sx), .out_src_size(sw),
      .out_dst_pos(dx), .out_dst_size(dw));

   lccs_axis #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_axis_y (
      .clock(clock), .en(en),
      .win_pos(lsy_ff), .win_size(lsh_ff), .lay_pos(ldy_ff), .lay_size(ldh_ff),
      .src_pos(req.surf_src_y), .src_size(req.surf_src_h),
      .pos(req.dst_y), .size(req.dst_h),
      .cropped(crop_y), .out_src_pos(sy), .out_src_size(sh),
      .out_dst_pos(dy), .out_dst_size(dh));

   logic crop;
   assign crop = crop_x || crop_y;

   assign rsp.valid         = valid_ff[LAT-1];
   assign rsp.fully_cropped = crop;
   assign rsp.out_src_x     = crop ? '0 : sx;
   assign rsp.out_src_y     = crop ? '0 : sy;
   assign rsp.out_src_w     = crop ? '0 : sw;
   assign rsp.out_src_h     = crop ? '0 : sh;
   assign rsp.out_dst_x     = crop ? '0 : dx;
   assign rsp.out_dst_y     = crop ? '0 : dy;
   assign rsp.out_dst_w     = crop ? '0 : dw;
   assign rsp.out_dst_h     = crop ? '0 : dh;
endmodule

[sim/lccs_tb_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lccs_tb_if: testbench view of the surface and rectangle channels
// Thin wrappers are not needed; the design interfaces are used directly.
// This file holds the rectangle beat struct used by the checker.
// -----------------------------------------------------------------------------
package lccs_tb_pkg;

   typedef struct packed {
      logic        fully_cropped;
      logic [16:0] src_x;
      logic [16:0] src_y;
      logic [16:0] src_w;
      logic [16:0] src_h;
      logic [16:0] dst_x;
      logic [16:0] dst_y;
      logic [16:0] dst_w;
      logic [16:0] dst_h;
   } rect_beat_t;

endpackage

[sim/lccs_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lccs_checker: rectangle predictor and scoreboard
// Tracks the layer window from the register port, computes the clipped and
// scaled rectangle of every accepted surface beat, and compares each result
// beat with the oldest prediction, field by field.
// -----------------------------------------------------------------------------
module lccs_checker (
   input  logic              clock,
   input  logic              reset,
   lccs_req_if               req,
   lccs_rsp_if               rsp,
   input  logic              csr_we,
   input  lccs_pkg::csr_index_type csr_index,
   input  logic [12:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   import lccs_pkg::*;
   import lccs_tb_pkg::*;

   localparam longint FIX_MAX = (64'd1 << 17) - 1;

   longint layer_win [8];
   rect_beat_t rect_queue [$];

   function automatic logic [16:0] clamp_fix(longint v);
      if (v < 0) return '0;
      if (v > FIX_MAX) return FIX_MAX[16:0];
      return v[16:0];
   endfunction

   // c > 0 means the near edge was cut; far edge trim follows the same ratio
   function automatic void clip_axis(input longint wpos, input longint wsize,
                                     inout longint pos, inout longint size,
                                     inout longint spos, inout longint ssize);
      longint d0, s0, c, t;
      d0 = size;
      s0 = ssize;
      c = wpos - pos;
      if (c > 0) begin
         t = (c * s0) / d0;
         pos = 0;
         size -= c;
         spos += t;
         ssize -= t;
      end else begin
         pos -= wpos;
      end
      c = pos + size - wsize;
      if (c > 0) begin
         size -= c;
         ssize -= (c * s0) / d0;
      end
   endfunction

   function automatic rect_beat_t predict_rect(longint sx, longint sy, longint sw, longint sh,
                                               longint dx, longint dy, longint dw, longint dh);
      rect_beat_t r;
      longint lsx, lsy, lsw, lsh;
      lsx = layer_win[CSR_LAYER_SRC_X];
      lsy = layer_win[CSR_LAYER_SRC_Y];
      lsw = layer_win[CSR_LAYER_SRC_W];
      lsh = layer_win[CSR_LAYER_SRC_H];
      r = '0;
      if (dw == 0 || dh == 0 || sw == 0 || sh == 0 || lsw == 0 || lsh == 0 ||
          dx >= lsx + lsw || dy >= lsy + lsh || dx + dw <= lsx || dy + dh <= lsy) begin
         r.fully_cropped = 1'b1;
         return r;
      end
      clip_axis(lsx, lsw, dx, dw, sx, sw);
      clip_axis(lsy, lsh, dy, dh, sy, sh);
      r.src_x = clamp_fix(sx);
      r.src_y = clamp_fix(sy);
      r.src_w = clamp_fix(sw);
      r.src_h = clamp_fix(sh);
      r.dst_x = clamp_fix((dx * layer_win[CSR_LAYER_DST_W] * 16) / lsw
                          + layer_win[CSR_LAYER_DST_X] * 16);
      r.dst_y = clamp_fix((dy * layer_win[CSR_LAYER_DST_H] * 16) / lsh
                          + layer_win[CSR_LAYER_DST_Y] * 16);
      r.dst_w = clamp_fix((dw * layer_win[CSR_LAYER_DST_W] * 16) / lsw);
      r.dst_h = clamp_fix((dh * layer_win[CSR_LAYER_DST_H] * 16) / lsh);
      return r;
   endfunction

   always @(posedge clock) begin
      rect_beat_t want, got;
      if (reset) begin
         layer_win = '{0, 0, LAYER_W_RESET, LAYER_H_RESET, 0, 0, LAYER_W_RESET, LAYER_H_RESET};
         rect_queue.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we)
            layer_win[csr_index] = csr_wdata;
         if (req.valid && req.ready)
            rect_queue.push_back(predict_rect(req.surf_src_x, req.surf_src_y, req.surf_src_w,
               req.surf_src_h, longint'(req.dst_x), longint'(req.dst_y), req.dst_w, req.dst_h));
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.fully_cropped, rsp.out_src_x, rsp.out_src_y, rsp.out_src_w,
                    rsp.out_src_h, rsp.out_dst_x, rsp.out_dst_y, rsp.out_dst_w, rsp.out_dst_h};
            if (rect_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result beat %p", $realtime, got);
               fail_count <= fail_count + 1;
            end else begin
               want = rect_queue.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= rect_queue.size();
      end
   end
endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: layer clip, crop and scale testbench
// Drives surface beats in bursts under a stalling receiver, walks the layer
// window through several settings, and reports the checker's verdict.
// -----------------------------------------------------------------------------
module tb_top;
   import lccs_pkg::*;

   localparam int LATENCY = 2 * 13 + 4 + 3;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic csr_we;
   csr_index_type csr_index;
   logic [12:0] csr_wdata;
   int fail_count, pending_count;
   longint cycle_count;
   int stall_mode;

   lccs_req_if req ();
   lccs_rsp_if rsp ();

   layer_clip_crop_and_scale dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lccs_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver stall pattern, changes mode now and then
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 3) != 0);
         2: rsp.ready <= ($urandom_range(0, 1) != 0);
         default: rsp.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic write_layer(input csr_index_type idx, input logic [12:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_pipe();
      while (pending_count != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // hold the beat until accepted; caller is at a falling edge
   task automatic send_surface(input logic [16:0] sx, sy, sw, sh,
                               input logic [13:0] dx, dy, input logic [12:0] dw, dh);
      req.valid <= 1'b1;
      req.surf_src_x <= sx;
      req.surf_src_y <= sy;
      req.surf_src_w <= sw;
      req.surf_src_h <= sh;
      req.dst_x <= dx;
      req.dst_y <= dy;
      req.dst_w <= dw;
      req.dst_h <= dh;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic idle_gap();
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   // random surface, mostly overlapping the current window
   task automatic send_random(input int lsx, lsy, lsw, lsh);
      logic [16:0] sx, sy, sw, sh;
      logic [13:0] dx, dy;
      logic [12:0] dw, dh;
      sx = 17'($urandom);
      sy = 17'($urandom);
      sw = ($urandom_range(0, 15) == 0) ? 17'h1ffff : 17'($urandom_range(0, 40000));
      sh = ($urandom_range(0, 15) == 0) ? 17'h1ffff : 17'($urandom_range(0, 40000));
      if ($urandom_range(0, 9) < 7) begin
         dx = 14'(lsx - 200 + int'($urandom_range(0, lsw + 300)));
         dy = 14'(lsy - 200 + int'($urandom_range(0, lsh + 300)));
         dw = 13'($urandom_range(1, lsw + 400));
         dh = 13'($urandom_range(1, lsh + 400));
      end else begin
         dx = 14'($urandom);
         dy = 14'($urandom);
         dw = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom);
         dh = ($urandom_range(0, 7) == 0) ? 13'd0 : 13'($urandom);
      end
      if ($urandom_range(0, 30) == 0) sw = '0;
      if ($urandom_range(0, 30) == 0) sh = '0;
      send_surface(sx, sy, sw, sh, dx, dy, dw, dh);
   endtask

   initial begin
      int win [8];
      int burst;
      cycle_count = 0;
      stall_mode = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_LAYER_SRC_X;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.surf_src_x = '0;
      req.surf_src_y = '0;
      req.surf_src_w = '0;
      req.surf_src_h = '0;
      req.dst_x = '0;
      req.dst_y = '0;
      req.dst_w = '0;
      req.dst_h = '0;
      rsp.ready = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at reset window 1920x1080
      send_surface(17'd0, 17'd0, 17'd16, 17'd16, 14'd0, 14'd0, 13'd1, 13'd1);
      send_surface(17'h1ffff, 17'h1ffff, 17'h1ffff, 17'h1ffff,
                   -14'sd8192, -14'sd8192, 13'h1fff, 13'h1fff);
      send_surface(17'd100, 17'd200, 17'd0, 17'd320, 14'd10, 14'd10, 13'd20, 13'd20);
      send_surface(17'd100, 17'd200, 17'd320, 17'd0, 14'd10, 14'd10, 13'd20, 13'd20);
      send_surface(17'd100, 17'd200, 17'd320, 17'd320, 14'd10, 14'd10, 13'd0, 13'd20);
      send_surface(17'd100, 17'd200, 17'd320, 17'd320, 14'd10, 14'd10, 13'd20, 13'd0);
      send_surface(17'd0, 17'd0, 17'd320, 17'd320, 14'd1920, 14'd10, 13'd20, 13'd20);
      send_surface(17'd0, 17'd0, 17'd320, 17'd320, 14'd10, 14'd1080, 13'd20, 13'd20);
      send_surface(17'd0, 17'd0, 17'd320, 17'd320, -14'sd20, 14'd10, 13'd20, 13'd20);
      send_surface(17'd0, 17'd0, 17'd320, 17'd320, 14'd10, -14'sd20, 13'd20, 13'd20);
      send_surface(17'd0, 17'd0, 17'd320, 17'd320, -14'sd19, -14'sd19, 13'd20, 13'd20);
      send_surface(17'd5, 17'd7, 17'd333, 17'd777, 14'd1900, 14'd1070, 13'd50, 13'd50);
      send_surface(17'd5, 17'd7, 17'd999, 17'd555, -14'sd30, 14'd1000, 13'd3000, 13'd200);
      send_surface(17'h1ffff, 17'd0, 17'h1ffff, 17'd1, 14'd8191, 14'd0, 13'd1, 13'd1);
      idle_gap();
      drain_pipe();

      // zero layer source width, then zero layer source height
      write_layer(CSR_LAYER_SRC_W, 13'd0);
      send_surface(17'd0, 17'd0, 17'd32, 17'd32, 14'd0, 14'd0, 13'd4, 13'd4);
      idle_gap();
      drain_pipe();
      write_layer(CSR_LAYER_SRC_W, 13'd100);
      write_layer(CSR_LAYER_SRC_H, 13'd0);
      send_surface(17'd0, 17'd0, 17'd32, 17'd32, 14'd0, 14'd0, 13'd4, 13'd4);
      idle_gap();
      drain_pipe();

      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: win = '{0, 0, 1920, 1080, 0, 0, 1920, 1080};
            1: win = '{0, 0, 8191, 8191, 8191, 8191, 8191, 8191};
            2: win = '{100, 50, 640, 480, 10, 20, 1280, 960};
            3: win = '{8191, 8191, 1, 1, 0, 0, 0, 0};
            4: win = '{0, 0, 1, 1, 8191, 0, 8191, 8191};
            5: win = '{300, 200, 1000, 700, 40, 30, 500, 350};
            default: for (int i = 0; i < 8; i++) win[i] = $urandom_range(1, 3000);
         endcase
         for (int i = 0; i < 8; i++)
            write_layer(csr_index_type'(i), 13'(win[i]));
         for (int n = 0; n < 250; ) begin
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < 250; b++, n++)
               send_random(win[0], win[1], win[2], win[3]);
            if ($urandom_range(0, 3) != 0)
               idle_gap();
         end
         idle_gap();
         drain_pipe();
      end

      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

[files.f]
design/lccs_pkg.sv
design/lccs_if.sv
design/lccs_div.sv
design/lccs_axis.sv
design/layer_clip_crop_and_scale.sv
sim/lccs_tb_if.sv
sim/lccs_checker.sv
sim/tb_top.sv
